>>> rtl/pdmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdmm_pkg
// Shared widths, constants, cell control type and symbol complement helper for the
// primer dimer max match core.
// ----------------------------------------------------------------------------
package pdmm_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int SYM_W           = 4;
   localparam int OVL_W           = 7;
   localparam int MATCH_W         = 7;

   localparam logic [MATCH_W-1:0] MATCH_MAX     = 7'd127;
   localparam logic [OVL_W-1:0]   MIN_OVL_RESET = 7'd4;

   // control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic             clear;
      logic             shift;
      logic             bcast_vld;
      logic [SYM_W-1:0] bcast_sym;
   } pdmm_cell_ctrl_type;

   // complement of an iupac mask: swap bits 0<->3 and 1<->2
   function automatic logic [SYM_W-1:0] comp_sym(input logic [SYM_W-1:0] s);
      return {s[0], s[1], s[2], s[3]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/pdmm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdmm_req_if
// Request channel: one nucleotide symbol per request with valid/ready.
// ----------------------------------------------------------------------------
interface pdmm_req_if
   import pdmm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [SYM_W-1:0] symbol;
   logic             last_symbol;

   modport source (output valid, output req_type, output symbol, output last_symbol,
                   input ready);
   modport sink   (input valid, input req_type, input symbol, input last_symbol,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/pdmm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdmm_rsp_if
// Response channel: best match count and length error with valid/ready.
// ----------------------------------------------------------------------------
interface pdmm_rsp_if
   import pdmm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MATCH_W-1:0] max_matches;
   logic               length_error;

   modport source (output valid, output max_matches, output length_error, input ready);
   modport sink   (input valid, input max_matches, input length_error, output ready);
endinterface
`default_nettype wire

>>> rtl/primer_dimer_max_match_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primer_dimer_max_match_core
// Largest count of equal symbols between a primer and the reverse complement
// of another over all sliding alignments, computed on a chain of cells.
//
// Usage:
//   req_chan carries one symbol per request; req_type picks the first (0) or
//   second (1) primer. A second-primer request with last_symbol set closes the
//   pair and starts the computation; rsp_chan then returns one response.
//   csr_wr_en/csr_wr_data write min_overlap (reset value 4); the user must
//   write it only while idle, which the core does not enforce. Symbol
//   requests are accepted while the core is idle. After the closing request
//   the core shifts the shorter primer (lr symbols) into the cell chain,
//   then streams the longer one (lb symbols) across it and drains the chain
//   of MAX_LEN cells before the response is ready. A pair with an empty or
//   overflowed primer skips the chain and goes straight to the response.
//   req_chan.ready is low during the computation.
// Reset and stall:
//   Reset (synchronous) empties both primers and restores min_overlap.
//   The response sits in an output register; symbols for the next pair are
//   taken while it waits, and the next result waits until it is taken.
// ----------------------------------------------------------------------------
module primer_dimer_max_match_core
   import pdmm_pkg::*;
   #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
   ) (
   input  wire logic             clock,
   input  wire logic             reset,
   pdmm_req_if.sink              req_chan,
   pdmm_rsp_if.source            rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [OVL_W-1:0] csr_wr_data
);

   localparam int AW   = $clog2(MAX_LEN);
   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int SW   = $clog2(3 * MAX_LEN);
   localparam int CMPW = (LW > OVL_W) ? LW : OVL_W;
   localparam int SATW = (LW > MATCH_W) ? LW : MATCH_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      first_len_ff, first_len_in;
   logic [LW-1:0]      second_len_ff, second_len_in;
   logic               ovf_ff, ovf_in;
   logic               base_sel_ff, base_sel_in;
   logic [LW-1:0]      lb_ff, lb_in;
   logic [LW-1:0]      lr_ff, lr_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_sel_ff, rd_sel_in;
   logic               rd_sweep_ff, rd_sweep_in;
   logic [LW-1:0]      best_ff, best_in;
   logic               err_ff, err_in;
   logic [OVL_W-1:0]   min_ovl_ff, min_ovl_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [MATCH_W-1:0] rsp_max_ff, rsp_max_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_acc;
   logic               first_full, second_full;
   logic               wr0_en, wr1_en;
   logic [LW-1:0]      sec_len_new;
   logic               ovf_new;
   logic               pair_err;
   logic               chain_clear;
   logic [AW-1:0]      rd_addr;
   logic [SW-1:0]      base_off;
   logic [SW-1:0]      sweep_end;
   logic               base_vld;
   logic [SYM_W-1:0]   rd0_data, rd1_data, rd_sym;
   logic [OVL_W-1:0]   thresh;
   logic               tail_ok;
   logic [SATW-1:0]    best_ext;
   pdmm_cell_ctrl_type cell_ctrl;

   logic [SYM_W-1:0]   rc_sym_w [MAX_LEN];
   logic               rc_vld_w [MAX_LEN];
   logic [LW-1:0]      cnt_w    [MAX_LEN];
   logic [LW-1:0]      ovl_w    [MAX_LEN];

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign first_full     = (first_len_ff == LW'(MAX_LEN));
   assign second_full    = (second_len_ff == LW'(MAX_LEN));
   assign wr0_en         = req_acc && !req_chan.req_type && !first_full;
   assign wr1_en         = req_acc && req_chan.req_type && !second_full;
   assign sec_len_new    = second_full ? second_len_ff : second_len_ff + LW'(1);
   assign ovf_new        = ovf_ff || second_full;
   assign pair_err       = ovf_new || (first_len_ff == '0);

   // stream index of the base runs lr-1 steps behind the sweep counter
   assign base_off  = step_ff - SW'(lr_ff) + SW'(1);
   assign base_vld  = (step_ff >= SW'(lr_ff) - SW'(1))
                   && (step_ff < SW'(lr_ff) + SW'(lb_ff) - SW'(1));
   assign sweep_end = SW'(lr_ff) + SW'(lb_ff) + SW'(MAX_LEN) - SW'(1);

   assign thresh   = (min_ovl_ff == '0) ? OVL_W'(1) : min_ovl_ff;
   assign tail_ok  = (ovl_w[MAX_LEN-1] == lr_ff)
                  || (CMPW'(ovl_w[MAX_LEN-1]) >= CMPW'(thresh));
   assign best_ext = SATW'(best_ff);

   always_comb begin
      state_in      = state_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      base_sel_in   = base_sel_ff;
      lb_in         = lb_ff;
      lr_in         = lr_ff;
      step_in       = step_ff;
      rd_vld_in     = 1'b0;
      rd_sel_in     = rd_sel_ff;
      rd_sweep_in   = rd_sweep_ff;
      best_in       = best_ff;
      err_in        = err_ff;
      min_ovl_in    = csr_wr_en ? csr_wr_data : min_ovl_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_max_in    = rsp_max_ff;
      rsp_err_in    = rsp_err_ff;
      chain_clear   = 1'b0;
      rd_addr       = step_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_chan.req_type) begin
                  if (first_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     first_len_in = first_len_ff + LW'(1);
                  end
               end else begin
                  second_len_in = sec_len_new;
                  ovf_in        = ovf_new;
                  if (req_chan.last_symbol) begin
                     base_sel_in = (first_len_ff < sec_len_new);
                     lb_in       = (first_len_ff < sec_len_new) ? sec_len_new : first_len_ff;
                     lr_in       = (first_len_ff < sec_len_new) ? first_len_ff : sec_len_new;
                     err_in      = pair_err;
                     best_in     = '0;
                     step_in     = '0;
                     chain_clear = 1'b1;
                     state_in    = pair_err ? ST_EMIT : ST_FILL;
                  end
               end
            end
         end
         ST_FILL: begin
            // shorter primer in forward order; the chain reverses it
            rd_vld_in   = (step_ff < SW'(lr_ff));
            rd_sel_in   = !base_sel_ff;
            rd_sweep_in = 1'b0;
            if (step_ff == SW'(lr_ff)) begin
               step_in  = '0;
               state_in = ST_SWEEP;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_SWEEP: begin
            rd_addr     = base_off[AW-1:0];
            rd_vld_in   = base_vld;
            rd_sel_in   = base_sel_ff;
            rd_sweep_in = 1'b1;
            if (tail_ok && (cnt_w[MAX_LEN-1] > best_ff)) begin
               best_in = cnt_w[MAX_LEN-1];
            end
            if (step_ff == sweep_end) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_err_in    = err_ff;
               rsp_max_in    = err_ff ? '0
                             : (best_ext > SATW'(MATCH_MAX)) ? MATCH_MAX
                             : best_ext[MATCH_W-1:0];
               first_len_in  = '0;
               second_len_in = '0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         base_sel_ff   <= 1'b0;
         lb_ff         <= '0;
         lr_ff         <= '0;
         step_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rd_sel_ff     <= 1'b0;
         rd_sweep_ff   <= 1'b0;
         best_ff       <= '0;
         err_ff        <= 1'b0;
         min_ovl_ff    <= MIN_OVL_RESET;
         rsp_vld_ff    <= 1'b0;
         rsp_max_ff    <= '0;
         rsp_err_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         base_sel_ff   <= base_sel_in;
         lb_ff         <= lb_in;
         lr_ff         <= lr_in;
         step_ff       <= step_in;
         rd_vld_ff     <= rd_vld_in;
         rd_sel_ff     <= rd_sel_in;
         rd_sweep_ff   <= rd_sweep_in;
         best_ff       <= best_in;
         err_ff        <= err_in;
         min_ovl_ff    <= min_ovl_in;
         rsp_vld_ff    <= rsp_vld_in;
         rsp_max_ff    <= rsp_max_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.max_matches  = rsp_max_ff;
   assign rsp_chan.length_error = rsp_err_ff;

   pdmm_store #(.MAX_LEN(MAX_LEN)) u_first_store (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (first_len_ff[AW-1:0]),
      .wr_data (req_chan.symbol),
      .rd_addr (rd_addr),
      .rd_data (rd0_data)
   );

   pdmm_store #(.MAX_LEN(MAX_LEN)) u_second_store (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (second_len_ff[AW-1:0]),
      .wr_data (req_chan.symbol),
      .rd_addr (rd_addr),
      .rd_data (rd1_data)
   );

   assign rd_sym = rd_sel_ff ? rd1_data : rd0_data;

   always_comb begin
      cell_ctrl.clear     = chain_clear;
      cell_ctrl.shift     = rd_vld_ff && !rd_sweep_ff;
      cell_ctrl.bcast_vld = rd_vld_ff && rd_sweep_ff;
      cell_ctrl.bcast_sym = rd_sym;
   end

   // partial sums move one cell per cycle; a fresh alignment enters cell 0
   for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
      if (j == 0) begin : g_head
         pdmm_cell #(.CNT_W(LW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .prev_rc_sym (comp_sym(rd_sym)),
            .prev_rc_vld (1'b1),
            .prev_cnt    ('0),
            .prev_ovl    ('0),
            .rc_sym      (rc_sym_w[j]),
            .rc_vld      (rc_vld_w[j]),
            .cnt         (cnt_w[j]),
            .ovl         (ovl_w[j])
         );
      end else begin : g_body
         pdmm_cell #(.CNT_W(LW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .prev_rc_sym (rc_sym_w[j-1]),
            .prev_rc_vld (rc_vld_w[j-1]),
            .prev_cnt    (cnt_w[j-1]),
            .prev_ovl    (ovl_w[j-1]),
            .rc_sym      (rc_sym_w[j]),
            .rc_vld      (rc_vld_w[j]),
            .cnt         (cnt_w[j]),
            .ovl         (ovl_w[j])
         );
      end
   end

`ifndef SYNTHESIS
   a_tail_cnt_le_ovl: assert property (@(posedge clock) disable iff (reset)
      cnt_w[MAX_LEN-1] <= ovl_w[MAX_LEN-1])
      else $error("match count exceeds overlap at chain tail");

   a_tail_ovl_le_lr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (ovl_w[MAX_LEN-1] <= lr_ff))
      else $error("overlap exceeds shorter primer length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (first_len_ff <= LW'(MAX_LEN)) && (second_len_ff <= LW'(MAX_LEN)))
      else $error("primer length beyond store depth");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_err_ff) |-> (rsp_max_ff == '0))
      else $error("error response with nonzero count");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=>
         (first_len_ff == '0 && second_len_ff == '0 && rsp_vld_ff))
      else $error("pair state not cleared after response");
`endif

endmodule
`default_nettype wire

>>> rtl/pdmm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdmm_store
// Symbol store for one primer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdmm_store
   import pdmm_pkg::*;
   #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
   ) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(MAX_LEN)-1:0] wr_addr,
   input  wire logic [SYM_W-1:0]           wr_data,
   input  wire logic [$clog2(MAX_LEN)-1:0] rd_addr,
   output logic      [SYM_W-1:0]           rd_data
);

   logic [SYM_W-1:0] mem [MAX_LEN];
   logic [SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/pdmm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdmm_cell
// One alignment cell: holds a reverse-complement symbol and adds its match
// and overlap contribution to the partial sum passing from its left neighbor.
// ----------------------------------------------------------------------------
module pdmm_cell
   import pdmm_pkg::*;
   #(
   parameter int CNT_W = 7
   ) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pdmm_cell_ctrl_type ctrl,
   input  wire logic [SYM_W-1:0]   prev_rc_sym,
   input  wire logic               prev_rc_vld,
   input  wire logic [CNT_W-1:0]   prev_cnt,
   input  wire logic [CNT_W-1:0]   prev_ovl,
   output logic      [SYM_W-1:0]   rc_sym,
   output logic                    rc_vld,
   output logic      [CNT_W-1:0]   cnt,
   output logic      [CNT_W-1:0]   ovl
);

   logic [SYM_W-1:0] rc_sym_ff, rc_sym_in;
   logic             rc_vld_ff, rc_vld_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] ovl_ff, ovl_in;
   logic             hit;

   always_comb begin
      hit    = rc_vld_ff && ctrl.bcast_vld;
      cnt_in = prev_cnt + CNT_W'(hit && (rc_sym_ff == ctrl.bcast_sym));
      ovl_in = prev_ovl + CNT_W'(hit);
      rc_sym_in = rc_sym_ff;
      rc_vld_in = rc_vld_ff;
      if (ctrl.clear) begin
         rc_vld_in = 1'b0;
      end else if (ctrl.shift) begin
         rc_sym_in = prev_rc_sym;
         rc_vld_in = prev_rc_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_vld_ff <= 1'b0;
         cnt_ff    <= '0;
         ovl_ff    <= '0;
      end else begin
         rc_vld_ff <= rc_vld_in;
         cnt_ff    <= cnt_in;
         ovl_ff    <= ovl_in;
      end
   end

   always_ff @(posedge clock) begin
      rc_sym_ff <= rc_sym_in;
   end

   assign rc_sym = rc_sym_ff;
   assign rc_vld = rc_vld_ff;
   assign cnt    = cnt_ff;
   assign ovl    = ovl_ff;

endmodule
`default_nettype wire
